// ===== rtl/core/triangle_height_rasterizer_macros.svh =====
// Assertion macros for the triangle height rasterizer
`ifndef TRIANGLE_HEIGHT_RASTERIZER_MACROS_SVH
`define TRIANGLE_HEIGHT_RASTERIZER_MACROS_SVH

// same-cycle implication
`define THR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define THR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/thr_pkg.sv =====
// Types, constants and helpers shared by the triangle height rasterizer
package thr_pkg;

    localparam int MAP_WIDTH  = 256;
    localparam int MAP_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAP_WIDTH);
    localparam int ROW_W      = $clog2(MAP_HEIGHT);
    localparam int ADDR_W     = $clog2(MAP_WIDTH * MAP_HEIGHT);
    localparam int MEM_DEPTH  = MAP_WIDTH * MAP_HEIGHT;

    localparam int COORD_W = 16;
    localparam int H_W     = 16;
    localparam int BOX_W   = 13;
    localparam int DIFF_W  = 17;
    localparam int OFS_W   = 18;
    localparam int PROD_W  = DIFF_W + OFS_W;
    localparam int W_W     = 38;
    localparam int MP_W    = W_W - 1 + H_W;
    localparam int NUM_W   = 56;
    localparam int REM_W   = NUM_W - H_W;
    localparam int CNT_W   = 17;
    localparam int STEP_W  = 4;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 40;
    localparam int KIND_W     = 2;

    localparam logic [STEP_W-1:0] SETUP_LAST = STEP_W'(7);
    localparam logic [STEP_W-1:0] MUL_LAST   = STEP_W'(2);
    localparam logic [STEP_W-1:0] DIV_LAST   = STEP_W'(H_W - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_WR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEM, ST_RDWAIT, ST_BOX, ST_SETUP, ST_CHECK,
        ST_PIX, ST_MUL, ST_DIV, ST_WRITE, ST_DONE
    } state_t;

    typedef struct packed {
        logic idle;
        logic load;
        logic mem_op;
        logic rd_cap;
        logic box;
        logic setup;
        logic check;
        logic mul;
        logic div;
        logic wr_pix;
        logic advance;
        logic result;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] in_kind;
        logic [KIND_W-1:0] kind;
        logic              step_last;
        logic              skip_draw;
        logic              covered;
        logic              scan_end;
        logic              out_free;
    } sts_t;

    // truncate signed Q12.4 toward zero
    function automatic logic signed [BOX_W-1:0] trunc_q4(input logic signed [COORD_W-1:0] v);
        logic [COORD_W:0] mag;
        logic [BOX_W-1:0] t;
        mag = v[COORD_W-1] ? -{v[COORD_W-1], v} : {1'b0, v};
        t   = mag[COORD_W:4];
        return v[COORD_W-1] ? -$signed(t) : $signed(t);
    endfunction

endpackage

// ===== rtl/core/thr_ctrl.sv =====
// Sequencer for requests: memory access, draw setup and pixel scan
module thr_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  thr_pkg::sts_t   sts,
    output thr_pkg::cmd_t   cmd
);

    thr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= thr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            thr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (sts.in_kind)
                        thr_pkg::KIND_WR, thr_pkg::KIND_RD: state_next = thr_pkg::ST_MEM;
                        thr_pkg::KIND_DRAW: state_next = thr_pkg::ST_BOX;
                        default: state_next = thr_pkg::ST_DONE;
                    endcase
                end
            end
            thr_pkg::ST_MEM: begin
                state_next = (sts.kind == thr_pkg::KIND_RD) ? thr_pkg::ST_RDWAIT
                                                            : thr_pkg::ST_DONE;
            end
            thr_pkg::ST_RDWAIT: state_next = thr_pkg::ST_DONE;
            thr_pkg::ST_BOX: state_next = thr_pkg::ST_SETUP;
            thr_pkg::ST_SETUP: begin
                if (sts.step_last) state_next = thr_pkg::ST_CHECK;
            end
            thr_pkg::ST_CHECK: begin
                state_next = sts.skip_draw ? thr_pkg::ST_DONE : thr_pkg::ST_PIX;
            end
            thr_pkg::ST_PIX: begin
                if (sts.covered) begin
                    state_next = thr_pkg::ST_MUL;
                end else if (sts.scan_end) begin
                    state_next = thr_pkg::ST_DONE;
                end
            end
            thr_pkg::ST_MUL: begin
                if (sts.step_last) state_next = thr_pkg::ST_DIV;
            end
            thr_pkg::ST_DIV: begin
                if (sts.step_last) state_next = thr_pkg::ST_WRITE;
            end
            thr_pkg::ST_WRITE: begin
                state_next = sts.scan_end ? thr_pkg::ST_DONE : thr_pkg::ST_PIX;
            end
            thr_pkg::ST_DONE: begin
                if (sts.out_free) state_next = thr_pkg::ST_IDLE;
            end
            default: state_next = thr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.idle    = (state_reg == thr_pkg::ST_IDLE);
        cmd.load    = (state_reg == thr_pkg::ST_IDLE) && s_tvalid;
        cmd.mem_op  = (state_reg == thr_pkg::ST_MEM);
        cmd.rd_cap  = (state_reg == thr_pkg::ST_RDWAIT);
        cmd.box     = (state_reg == thr_pkg::ST_BOX);
        cmd.setup   = (state_reg == thr_pkg::ST_SETUP);
        cmd.check   = (state_reg == thr_pkg::ST_CHECK);
        cmd.mul     = (state_reg == thr_pkg::ST_MUL);
        cmd.div     = (state_reg == thr_pkg::ST_DIV);
        cmd.wr_pix  = (state_reg == thr_pkg::ST_WRITE);
        cmd.advance = ((state_reg == thr_pkg::ST_PIX) && !sts.covered)
                   || (state_reg == thr_pkg::ST_WRITE);
        cmd.result  = (state_reg == thr_pkg::ST_DONE) && sts.out_free;
    end

endmodule

// ===== rtl/core/thr_dp.sv =====
// Datapath: height map, edge setup, scan counters, interpolation and result register
module thr_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  thr_pkg::cmd_t                       cmd,
    output thr_pkg::sts_t                       sts,
    input  logic [thr_pkg::KIND_W-1:0]          s_tuser,
    input  logic [thr_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [thr_pkg::OUT_DATA_W-1:0]      m_tdata
);

    localparam int CW = thr_pkg::COORD_W;
    localparam int BW = thr_pkg::BOX_W;
    localparam int WW = thr_pkg::W_W;

    logic [thr_pkg::KIND_W-1:0]   kind_reg;
    logic [7:0]                   col_reg, row_reg;
    logic                         inside_reg;
    logic signed [CW-1:0]         vx_reg [3];
    logic signed [CW-1:0]         vy_reg [3];
    logic [thr_pkg::H_W-1:0]      vh_reg [3];

    logic signed [thr_pkg::DIFF_W-1:0] a_reg [3];
    logic signed [thr_pkg::DIFF_W-1:0] b_reg [3];
    logic signed [thr_pkg::OFS_W-1:0]  dx_reg [3];
    logic signed [thr_pkg::OFS_W-1:0]  dy_reg [3];
    logic signed [thr_pkg::DIFF_W-1:0] ex_reg, ey_reg;
    logic signed [BW-1:0]              maxx_reg, maxy_reg, minx_reg;
    logic                              empty_reg;
    logic [thr_pkg::COL_W-1:0]         x_reg;
    logic [thr_pkg::ROW_W-1:0]         y_reg;

    logic signed [WW-1:0] acc_reg, sum_reg;
    logic signed [WW-1:0] w_reg [3];
    logic signed [WW-1:0] wrow_reg [3];
    logic [thr_pkg::STEP_W-1:0]  step_reg;
    logic [thr_pkg::NUM_W-1:0]   num_reg;
    logic [thr_pkg::REM_W-1:0]   rem_reg;
    logic [thr_pkg::H_W-1:0]     q_reg;

    logic [thr_pkg::H_W-1:0]     rv_reg;
    logic [thr_pkg::CNT_W-1:0]   cnt_reg;
    logic                        degen_reg;
    logic                        m_tvalid_reg;
    logic [thr_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [thr_pkg::H_W-1:0]     mem [thr_pkg::MEM_DEPTH];
    logic [thr_pkg::H_W-1:0]     mem_q;
    logic [thr_pkg::ADDR_W-1:0]  mem_addr;
    logic                        mem_we, mem_re;

    // bounding box
    logic signed [CW-1:0] mnx, mxx, mny, mxy;
    logic signed [BW-1:0] tminx, tmaxx, tminy, tmaxy, cminx, cmaxx, cminy, cmaxy;
    logic signed [thr_pkg::OFS_W-1:0] px0, py0;

    // setup multiplier
    logic signed [thr_pkg::OFS_W-1:0]  ma;
    logic signed [thr_pkg::DIFF_W-1:0] mb;
    logic signed [thr_pkg::PROD_W-1:0] prod;
    logic signed [WW-1:0]              acc_diff;

    // pixel evaluation
    logic                        neg;
    logic [WW-2:0]               usum;
    logic signed [WW-1:0]        aw_sel;
    logic [thr_pkg::H_W-1:0]     h_sel;
    logic [thr_pkg::MP_W-1:0]    mp;
    logic [thr_pkg::REM_W-1:0]   rem_src, rem_t;
    logic [thr_pkg::H_W-1:0]     q_src;
    logic                        ge;
    logic                        last_x;
    logic [thr_pkg::ROW_W-1:0]   draw_row;

    always_comb begin
        mnx = vx_reg[0];
        if (vx_reg[1] < mnx) mnx = vx_reg[1];
        if (vx_reg[2] < mnx) mnx = vx_reg[2];
        mxx = vx_reg[0];
        if (vx_reg[1] > mxx) mxx = vx_reg[1];
        if (vx_reg[2] > mxx) mxx = vx_reg[2];
        mny = vy_reg[0];
        if (vy_reg[1] < mny) mny = vy_reg[1];
        if (vy_reg[2] < mny) mny = vy_reg[2];
        mxy = vy_reg[0];
        if (vy_reg[1] > mxy) mxy = vy_reg[1];
        if (vy_reg[2] > mxy) mxy = vy_reg[2];
        tminx = thr_pkg::trunc_q4(mnx);
        tmaxx = thr_pkg::trunc_q4(mxx);
        tminy = thr_pkg::trunc_q4(mny);
        tmaxy = thr_pkg::trunc_q4(mxy);
        cminx = (tminx < 0) ? BW'(0) : tminx;
        cminy = (tminy < 0) ? BW'(0) : tminy;
        cmaxx = (tmaxx > BW'(thr_pkg::MAP_WIDTH - 1))  ? BW'(thr_pkg::MAP_WIDTH - 1)  : tmaxx;
        cmaxy = (tmaxy > BW'(thr_pkg::MAP_HEIGHT - 1)) ? BW'(thr_pkg::MAP_HEIGHT - 1) : tmaxy;
        px0 = thr_pkg::OFS_W'(cminx) <<< 4;
        py0 = thr_pkg::OFS_W'(cminy) <<< 4;
    end

    always_comb begin
        case (step_reg[2:0])
            3'd0: begin ma = dy_reg[0]; mb = b_reg[0]; end
            3'd1: begin ma = dx_reg[0]; mb = a_reg[0]; end
            3'd2: begin ma = dy_reg[1]; mb = b_reg[1]; end
            3'd3: begin ma = dx_reg[1]; mb = a_reg[1]; end
            3'd4: begin ma = dy_reg[2]; mb = b_reg[2]; end
            3'd5: begin ma = dx_reg[2]; mb = a_reg[2]; end
            3'd6: begin ma = thr_pkg::OFS_W'(ey_reg); mb = b_reg[0]; end
            default: begin ma = thr_pkg::OFS_W'(ex_reg); mb = a_reg[0]; end
        endcase
        prod     = ma * mb;
        acc_diff = acc_reg - WW'(prod);
    end

    always_comb begin
        neg  = sum_reg[WW-1];
        usum = neg ? (WW-1)'(-sum_reg) : sum_reg[WW-2:0];
        case (step_reg[1:0])
            2'd0: begin aw_sel = w_reg[0]; h_sel = vh_reg[0]; end
            2'd1: begin aw_sel = w_reg[1]; h_sel = vh_reg[1]; end
            default: begin aw_sel = w_reg[2]; h_sel = vh_reg[2]; end
        endcase
        if (neg) aw_sel = -aw_sel;
        mp = aw_sel[WW-2:0] * h_sel;

        rem_src = (step_reg == '0) ? num_reg[thr_pkg::NUM_W-1:thr_pkg::H_W] : rem_reg;
        q_src   = (step_reg == '0) ? num_reg[thr_pkg::H_W-1:0] : q_reg;
        rem_t   = {rem_src[thr_pkg::REM_W-2:0], q_src[thr_pkg::H_W-1]};
        ge      = rem_t >= thr_pkg::REM_W'(usum);

        last_x   = (thr_pkg::COL_W'(maxx_reg) == x_reg);
        draw_row = thr_pkg::ROW_W'(thr_pkg::MAP_HEIGHT - 1) - y_reg;
    end

    always_comb begin
        sts           = '0;
        sts.in_kind   = s_tuser;
        sts.kind      = kind_reg;
        sts.step_last = (cmd.setup && step_reg == thr_pkg::SETUP_LAST)
                     || (cmd.mul && step_reg == thr_pkg::MUL_LAST)
                     || (cmd.div && step_reg == thr_pkg::DIV_LAST);
        sts.skip_draw = (sum_reg == '0) || empty_reg;
        sts.covered   = neg ? (w_reg[0] <= 0 && w_reg[1] <= 0 && w_reg[2] <= 0)
                            : (w_reg[0] >= 0 && w_reg[1] >= 0 && w_reg[2] >= 0);
        sts.scan_end  = last_x && (thr_pkg::ROW_W'(maxy_reg) == y_reg);
        sts.out_free  = !m_tvalid_reg || m_tready;
    end

    // memory port
    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = thr_pkg::ADDR_W'(row_reg) * thr_pkg::ADDR_W'(thr_pkg::MAP_WIDTH)
                 + thr_pkg::ADDR_W'(col_reg);
        if (cmd.mem_op) begin
            mem_we = inside_reg && (kind_reg == thr_pkg::KIND_WR);
            mem_re = (kind_reg == thr_pkg::KIND_RD);
        end
        if (cmd.wr_pix) begin
            mem_we   = 1'b1;
            mem_addr = thr_pkg::ADDR_W'(draw_row) * thr_pkg::ADDR_W'(thr_pkg::MAP_WIDTH)
                     + thr_pkg::ADDR_W'(x_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= cmd.wr_pix ? q_reg : vh_reg[0];
        end
        if (mem_re) begin
            mem_q <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (sts.step_last) begin
                step_reg <= '0;
            end else if (cmd.setup || cmd.mul || cmd.div) begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg   <= s_tuser;
            col_reg    <= s_tdata[7:0];
            row_reg    <= s_tdata[15:8];
            inside_reg <= (int'(s_tdata[7:0]) < thr_pkg::MAP_WIDTH)
                       && (int'(s_tdata[15:8]) < thr_pkg::MAP_HEIGHT);
            for (int i = 0; i < 3; i++) begin
                vx_reg[i] <= s_tdata[16 + 48*i +: 16];
                vy_reg[i] <= s_tdata[32 + 48*i +: 16];
                vh_reg[i] <= s_tdata[48 + 48*i +: 16];
            end
            rv_reg    <= '0;
            cnt_reg   <= '0;
            degen_reg <= 1'b0;
            sum_reg   <= '0;
            empty_reg <= 1'b0;
        end
        if (cmd.rd_cap) begin
            rv_reg <= inside_reg ? mem_q : '0;
        end
        if (cmd.box) begin
            // edge i runs from vertex (i+1)%3 to (i+2)%3
            for (int i = 0; i < 3; i++) begin
                a_reg[i]  <= thr_pkg::DIFF_W'(vy_reg[(i+2)%3]) - thr_pkg::DIFF_W'(vy_reg[(i+1)%3]);
                b_reg[i]  <= thr_pkg::DIFF_W'(vx_reg[(i+2)%3]) - thr_pkg::DIFF_W'(vx_reg[(i+1)%3]);
                dx_reg[i] <= px0 - thr_pkg::OFS_W'(vx_reg[(i+1)%3]);
                dy_reg[i] <= py0 - thr_pkg::OFS_W'(vy_reg[(i+1)%3]);
            end
            ex_reg    <= thr_pkg::DIFF_W'(vx_reg[0]) - thr_pkg::DIFF_W'(vx_reg[1]);
            ey_reg    <= thr_pkg::DIFF_W'(vy_reg[0]) - thr_pkg::DIFF_W'(vy_reg[1]);
            minx_reg  <= cminx;
            maxx_reg  <= cmaxx;
            maxy_reg  <= cmaxy;
            empty_reg <= (cminx > cmaxx) || (cminy > cmaxy);
            x_reg     <= thr_pkg::COL_W'(cminx);
            y_reg     <= thr_pkg::ROW_W'(cminy);
        end
        if (cmd.setup) begin
            if (!step_reg[0]) begin
                acc_reg <= WW'(prod);
            end else begin
                case (step_reg[2:1])
                    2'd0: begin w_reg[0] <= acc_diff; wrow_reg[0] <= acc_diff; end
                    2'd1: begin w_reg[1] <= acc_diff; wrow_reg[1] <= acc_diff; end
                    2'd2: begin w_reg[2] <= acc_diff; wrow_reg[2] <= acc_diff; end
                    default: sum_reg <= acc_diff;
                endcase
            end
        end
        if (cmd.check) begin
            degen_reg <= (sum_reg == '0);
        end
        if (cmd.mul) begin
            num_reg <= ((step_reg == '0) ? thr_pkg::NUM_W'(usum >> 1) : num_reg)
                     + thr_pkg::NUM_W'(mp);
        end
        if (cmd.div) begin
            rem_reg <= ge ? rem_t - thr_pkg::REM_W'(usum) : rem_t;
            q_reg   <= {q_src[thr_pkg::H_W-2:0], ge};
        end
        if (cmd.wr_pix && cnt_reg != thr_pkg::CNT_MAX) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.advance) begin
            if (!last_x) begin
                x_reg <= x_reg + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    w_reg[i] <= w_reg[i] - (WW'(a_reg[i]) <<< 4);
                end
            end else begin
                x_reg <= thr_pkg::COL_W'(minx_reg);
                y_reg <= y_reg + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    wrow_reg[i] <= wrow_reg[i] + (WW'(b_reg[i]) <<< 4);
                    w_reg[i]    <= wrow_reg[i] + (WW'(b_reg[i]) <<< 4);
                end
            end
        end
        if (cmd.result) begin
            m_tdata_reg <= {6'b0, degen_reg, cnt_reg, rv_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/triangle_height_rasterizer.sv =====
// Top level of the triangle height rasterizer: sequencer plus datapath
//
//  channel | direction | ports                  | contents
//  s_      | in        | tvalid tready tdata    | one request: write, read or draw
//          |           | tuser                  | request kind
//  m_      | out       | tvalid tready tdata    | one result per request
//
// Write: MEM, DONE; unused kind: DONE; read: MEM, RDWAIT (the registered map read), DONE.
// Draw: box, edge setup and check, then a scan of the box pixels with the 3-step weight
// multiply and the 16-step restoring divider per covered pixel.
// Reset clears only control state; the map holds garbage until written.
// A new request is taken while a finished result waits in the output register.
module triangle_height_rasterizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // col, row, x0, y0, h0, x1, y1, h1, x2, y2, h2
    input  logic [thr_pkg::IN_DATA_W-1:0]       s_tdata,
    // kind
    input  logic [thr_pkg::KIND_W-1:0]          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // read_value, pixels_written, degenerate, zero pad
    output logic [thr_pkg::OUT_DATA_W-1:0]      m_tdata
);

    thr_pkg::cmd_t cmd;
    thr_pkg::sts_t sts;

    thr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    thr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = cmd.idle;

endmodule

// ===== rtl/core/thr_checker.sv =====
// Port-level checks for the triangle height rasterizer, bound to the top level
`include "triangle_height_rasterizer_macros.svh"

module thr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    `THR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `THR_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
    `THR_ASSERT_NOW(a_degen_clean, m_tvalid && m_tdata[33], m_tdata[32:16] == 17'd0 && m_tdata[15:0] == 16'd0, "degenerate draw reports data")
    `THR_ASSERT_NOW(a_one_kind, m_tvalid, m_tdata[15:0] == 16'd0 || m_tdata[32:16] == 17'd0, "read value and pixel count both set")
    `THR_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "second request taken while busy")

endmodule

bind triangle_height_rasterizer thr_checker u_thr_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the triangle height rasterizer
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [15:0] x0, y0, h0, x1, y1, h1, x2, y2, h2;
    } req_t;

    typedef struct packed {
        logic [15:0] rv;
        logic [16:0] cnt;
        logic        dg;
    } res_t;

    typedef struct packed {
        req_t req;
        logic chk;
        res_t res;
    } dir_row_t;

    localparam int DIR_N     = 18;
    localparam int RAND_N    = 275;
    localparam int QUIET_MAX = 100000;
    localparam logic [1:0] KIND_NOP = 2'd3;
    localparam logic [1:0] KWR = thr_pkg::KIND_WR;
    localparam logic [1:0] KRD = thr_pkg::KIND_RD;
    localparam logic [1:0] KDR = thr_pkg::KIND_DRAW;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [thr_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic [thr_pkg::KIND_W-1:0]      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [thr_pkg::OUT_DATA_W-1:0]  m_tdata;

    logic [15:0] hmap [0:thr_pkg::MEM_DEPTH-1];
    bit          seen [0:thr_pkg::MEM_DEPTH-1];
    int          written_q[$];
    res_t        result_q[$];
    int          fails = 0;
    int          hold_cnt = 0;
    int          rx_cnt = 0;
    bit          long_done = 1'b0;
    bit          calm = 1'b0;
    int          quiet = 0;

    triangle_height_rasterizer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
        return (bx - ax) * (py - ay) - (by - ay) * (px - ax);
    endfunction

    function automatic int rand_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 70) return 0;
        if (r < 95) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // updates the height map copy and returns the expected result
    function automatic res_t predict_height(req_t r);
        res_t   o;
        longint vx[3], vy[3], vh[3];
        longint s, us, w0, w1, w2, px, py, num, val;
        longint mnx, mxx, mny, mxy;
        int     a, xx, yy;
        o = '0;
        case (r.kind)
            thr_pkg::KIND_WR: begin
                a = int'(r.row) * thr_pkg::MAP_WIDTH + int'(r.col);
                hmap[a] = r.h0;
                if (!seen[a]) begin
                    seen[a] = 1'b1;
                    written_q = {written_q, a};
                end
            end
            thr_pkg::KIND_RD: o.rv = hmap[int'(r.row) * thr_pkg::MAP_WIDTH + int'(r.col)];
            thr_pkg::KIND_DRAW: begin
                vx[0] = longint'($signed(r.x0)); vy[0] = longint'($signed(r.y0));
                vx[1] = longint'($signed(r.x1)); vy[1] = longint'($signed(r.y1));
                vx[2] = longint'($signed(r.x2)); vy[2] = longint'($signed(r.y2));
                vh[0] = longint'(r.h0); vh[1] = longint'(r.h1); vh[2] = longint'(r.h2);
                s = edge_val(vx[1], vy[1], vx[2], vy[2], vx[0], vy[0]);
                if (s == 0) begin
                    o.dg = 1'b1;
                end else begin
                    mnx = vx[0]; mxx = vx[0]; mny = vy[0]; mxy = vy[0];
                    for (int i = 1; i < 3; i++) begin
                        if (vx[i] < mnx) mnx = vx[i];
                        if (vx[i] > mxx) mxx = vx[i];
                        if (vy[i] < mny) mny = vy[i];
                        if (vy[i] > mxy) mxy = vy[i];
                    end
                    mnx = mnx / 16; mxx = mxx / 16; mny = mny / 16; mxy = mxy / 16;
                    if (mnx < 0) mnx = 0;
                    if (mny < 0) mny = 0;
                    if (mxx > thr_pkg::MAP_WIDTH - 1) mxx = thr_pkg::MAP_WIDTH - 1;
                    if (mxy > thr_pkg::MAP_HEIGHT - 1) mxy = thr_pkg::MAP_HEIGHT - 1;
                    us = (s < 0) ? -s : s;
                    for (yy = int'(mny); yy <= mxy; yy++) begin
                        for (xx = int'(mnx); xx <= mxx; xx++) begin
                            px = longint'(xx) * 16;
                            py = longint'(yy) * 16;
                            w0 = edge_val(vx[1], vy[1], vx[2], vy[2], px, py);
                            w1 = edge_val(vx[2], vy[2], vx[0], vy[0], px, py);
                            w2 = edge_val(vx[0], vy[0], vx[1], vy[1], px, py);
                            if (s < 0) begin
                                w0 = -w0; w1 = -w1; w2 = -w2;
                            end
                            if (w0 >= 0 && w1 >= 0 && w2 >= 0) begin
                                num = w0 * vh[0] + w1 * vh[1] + w2 * vh[2];
                                val = (num + us / 2) / us;
                                if (val > 65535) val = 65535;
                                a = (thr_pkg::MAP_HEIGHT - 1 - yy) * thr_pkg::MAP_WIDTH + xx;
                                hmap[a] = val[15:0];
                                if (!seen[a]) begin
                                    seen[a] = 1'b1;
                                    written_q = {written_q, a};
                                end
                                if (o.cnt != thr_pkg::CNT_MAX) o.cnt++;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // drive one request; called at a falling edge, returns at a falling edge
    task automatic send_request(req_t r, bit chk, res_t typed);
        res_t p;
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {r.h2, r.y2, r.x2, r.h1, r.y1, r.x1, r.h0, r.y0, r.x0, r.row, r.col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = predict_height(r);
        result_q = {result_q, chk ? typed : p};
        @(negedge aclk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    function automatic req_t random_request();
        req_t r;
        int   k, a, bx, by, sz;
        r = '0;
        r.col = 8'($urandom); r.row = 8'($urandom);
        r.x0 = 16'($urandom); r.y0 = 16'($urandom); r.h0 = 16'($urandom);
        r.x1 = 16'($urandom); r.y1 = 16'($urandom); r.h1 = 16'($urandom);
        r.x2 = 16'($urandom); r.y2 = 16'($urandom); r.h2 = 16'($urandom);
        k = int'($urandom_range(0, 99));
        if (k < 28 || (k < 58 && written_q.size() == 0)) begin
            r.kind = KWR;
        end else if (k < 58) begin
            r.kind = KRD;
            a = written_q[$urandom_range(0, written_q.size() - 1)];
            r.col = 8'(a % thr_pkg::MAP_WIDTH);
            r.row = 8'(a / thr_pkg::MAP_WIDTH);
        end else if (k < 95) begin
            r.kind = KDR;
            k = int'($urandom_range(0, 99));
            if (k < 65) begin
                sz = ($urandom_range(0, 9) == 0) ? 40 : 12;
                bx = int'($urandom_range(0, 4400)) - 200;
                by = int'($urandom_range(0, 4400)) - 200;
            end else if (k < 90) begin
                sz = 12;
                bx = int'($urandom_range(0, 65535 - 400)) - 32768;
                by = int'($urandom_range(0, 65535 - 400)) - 32768;
            end else begin
                sz = 0;
                bx = int'($urandom_range(0, 4000));
                by = int'($urandom_range(0, 4000));
            end
            r.x0 = 16'(bx + int'($urandom_range(0, sz * 16)));
            r.y0 = 16'(by + int'($urandom_range(0, sz * 16)));
            r.x1 = 16'(bx + int'($urandom_range(0, sz * 16)));
            r.y1 = 16'(by + int'($urandom_range(0, sz * 16)));
            r.x2 = 16'(bx + int'($urandom_range(0, sz * 16)));
            r.y2 = 16'(by + int'($urandom_range(0, sz * 16)));
        end else begin
            r.kind = KIND_NOP;
        end
        return r;
    endfunction

    // directed requests: map corners, read-back, unused kind, zero area,
    // boxes off the map, both windings, edge sliver, clipped corner
    dir_row_t dir_tab [DIR_N] = '{
        '{'{KWR,      8'd0,   8'd0,   16'h0, 16'h0, 16'h0000, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0}, 1'b1, '{16'h0, 17'd0, 1'b0}},
        '{'{KWR,      8'd255, 8'd255, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0}, 1'b1, '{16'h0, 17'd0, 1'b0}},
        '{'{KWR,      8'd255, 8'd0,   16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0}, 1'b1, '{16'h0, 17'd0, 1'b0}},
        '{'{KWR,      8'd0,   8'd255, 16'h0, 16'h0, 16'h1234, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0}, 1'b1, '{16'h0, 17'd0, 1'b0}},
        '{'{KRD,      8'd0,   8'd0,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 17'd0, 1'b0}},
        '{'{KRD,      8'd255, 8'd255, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0}, 1'b1, '{16'hFFFF, 17'd0, 1'b0}},
        '{'{KRD,      8'd255, 8'd0,   16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0}, 1'b1, '{16'h8000, 17'd0, 1'b0}},
        '{'{KRD,      8'd0,   8'd255, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0}, 1'b1, '{16'h1234, 17'd0, 1'b0}},
        '{'{KIND_NOP, 8'd255, 8'd255, 16'h00A0, 16'h0, 16'hFFFF, 16'h0, 16'h00A0, 16'hFFFF,
            16'h0, 16'h0, 16'hFFFF}, 1'b1, '{16'h0, 17'd0, 1'b0}},
        '{'{KDR,      8'd0,   8'd0,   16'h0010, 16'h0010, 16'hFFFF, 16'h0010, 16'h0010,
            16'hFFFF, 16'h0010, 16'h0010, 16'hFFFF}, 1'b1, '{16'h0, 17'd0, 1'b1}},
        '{'{KDR,      8'd0,   8'd0,   16'h0000, 16'h0000, 16'h1000, 16'h00A0, 16'h00A0,
            16'h2000, 16'h0140, 16'h0140, 16'h3000}, 1'b1, '{16'h0, 17'd0, 1'b1}},
        '{'{KDR,      8'd0,   8'd0,   16'h8000, 16'h8000, 16'h0, 16'h8300, 16'h8000,
            16'hFFFF, 16'h8000, 16'h8300, 16'h8000}, 1'b1, '{16'h0, 17'd0, 1'b0}},
        '{'{KDR,      8'd0,   8'd0,   16'h7FFF, 16'h0000, 16'h0, 16'h7D00, 16'h00A0,
            16'hFFFF, 16'h7FFF, 16'h0140, 16'h8000}, 1'b1, '{16'h0, 17'd0, 1'b0}},
        '{'{KDR,      8'd0,   8'd0,   16'h0000, 16'h0000, 16'h0000, 16'h00A0, 16'h0000,
            16'hFFFF, 16'h0000, 16'h00A0, 16'h8000}, 1'b0, '0},
        '{'{KDR,      8'd0,   8'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h00A0,
            16'h8000, 16'h00A0, 16'h0000, 16'hFFFF}, 1'b0, '0},
        '{'{KDR,      8'd0,   8'd0,   16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0000,
            16'hFFFF, 16'h7FFF, 16'h0020, 16'hFFFF}, 1'b0, '0},
        '{'{KDR,      8'd0,   8'd0,   16'h0FA0, 16'h0FA0, 16'h0001, 16'h1068, 16'h0FF0,
            16'h7FFF, 16'h0FF0, 16'h1068, 16'hFFFE}, 1'b0, '0},
        '{'{KRD,      8'd1,   8'd254, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            16'h0, 16'h0, 16'h0}, 1'b0, '0}
    };

    initial begin
        req_t r;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int i = 0; i < DIR_N; i++) begin
            send_request(dir_tab[i].req, dir_tab[i].chk, dir_tab[i].res);
            idle_gap(rand_gap());
        end
        for (int i = 0; i < RAND_N; i++) begin
            calm = (i >= 40 && i < 80);
            if (i == 200 && result_q.size() != 0) begin
                s_tvalid <= 1'b0;
                while (result_q.size() != 0) @(negedge aclk);
            end
            r = random_request();
            send_request(r, 1'b0, '0);
            idle_gap(calm ? 0 : rand_gap());
        end
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    always @(negedge aclk) begin
        if (!long_done && rx_cnt >= 140) begin
            m_tready  <= 1'b0;
            hold_cnt  <= 400;
            long_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (!m_tready || $urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= 1'b0;
            hold_cnt <= ($urandom_range(0, 19) == 0) ? int'($urandom_range(10, 40))
                                                       : int'($urandom_range(0, 2));
        end
    end

    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t: exp no result got %h", $time, m_tdata);
                fails++;
            end else begin
                e = result_q.pop_front();
                rx_cnt++;
                if (m_tdata[15:0] !== e.rv) begin
                    $display("%0t: read_value exp %h got %h", $time, e.rv, m_tdata[15:0]);
                    fails++;
                end
                if (m_tdata[32:16] !== e.cnt) begin
                    $display("%0t: pixels_written exp %0d got %0d", $time, e.cnt,
                             m_tdata[32:16]);
                    fails++;
                end
                if (m_tdata[33] !== e.dg) begin
                    $display("%0t: degenerate exp %b got %b", $time, e.dg, m_tdata[33]);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $display("testbench failed");
            $finish;
        end
    end

endmodule
